@@ design/cfpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cfpt_pkg;

	// Defaults for the top-level parameters
	localparam int GRID_MAX_DEF        = 1024;
	localparam int SAMPLE_WIDTH_DEF    = 16;
	localparam int PHASE_WIDTH_DEF     = 32;
	localparam int ROTATION_STAGES_DEF = 16;

	// Register and field widths fixed by the register map
	localparam int STEP_WIDTH     = 32;
	localparam int GRID_WIDTH     = 11;
	localparam int TURN_WIDTH     = 32;
	localparam int ZW             = 32;
	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = 32;

	localparam logic [GRID_WIDTH-1:0] GRID_RESET = 11'd256;

	// CORDIC gain compensation, Q30, and the output guard bits
	localparam int GAIN_Q30   = 652032874;
	localparam int GAIN_SHIFT = 16;
	localparam int GUARD_BITS = 14;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_ROW_STEP = 2'd0,
		REG_COL_STEP = 2'd1,
		REG_GRID     = 2'd2
	} reg_idx_t;

	// Control that travels alongside each sample
	typedef struct packed {
		logic vld;
		logic fe;
	} tag_t;

	// Arctangent of 2^-i in 2^-32 turns
	localparam logic [31:0] ATAN_TURNS [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage

`default_nettype wire

@@ design/complex_field_phase_tilt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Each sample passes the capture, pre-scale, quarter-turn, cell and output registers.
// Throughput: one sample per cycle; the fixed row of rotation cells is fully pipelined,
// and the whole pipeline holds only while the output register waits on m_tready.
// Reset (arst_n low): clears the position counters, phase accumulators and valid tags,
// and loads the registers with zero steps and a 256-point grid.
module complex_field_phase_tilt #(
	parameter int GRID_MAX        = cfpt_pkg::GRID_MAX_DEF,
	parameter int SAMPLE_WIDTH    = cfpt_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_WIDTH     = cfpt_pkg::PHASE_WIDTH_DEF,
	parameter int ROTATION_STAGES = cfpt_pkg::ROTATION_STAGES_DEF,
	localparam int DW             = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [cfpt_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx,
	input  wire [cfpt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [DW-1:0]                        s_tdata,  // in_re, in_im
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [DW-1:0]                       m_tdata,  // out_re, out_im
	output logic                                m_tlast   // frame_end
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int XW  = SAMPLE_WIDTH + 16;
	localparam int PWM = SAMPLE_WIDTH + 31;
	localparam int ZW  = cfpt_pkg::ZW;
	localparam int GB  = cfpt_pkg::GUARD_BITS;

	localparam logic signed [PWM-1:0] GAIN     = PWM'(cfpt_pkg::GAIN_Q30);
	localparam logic signed [PWM-1:0] GAIN_RND = PWM'(1) <<< (cfpt_pkg::GAIN_SHIFT - 1);
	localparam logic signed [XW-1:0]  OUT_RND  = XW'(1) <<< (GB - 1);
	localparam logic signed [XW-1:0]  SAT_HI   = XW'((64'sd1 <<< (SW - 1)) - 1);
	localparam logic signed [XW-1:0]  SAT_LO   = -SAT_HI - XW'(1);

	// Configuration registers
	logic [cfpt_pkg::STEP_WIDTH-1:0] row_step_q;
	logic [cfpt_pkg::STEP_WIDTH-1:0] col_step_q;
	logic [cfpt_pkg::GRID_WIDTH-1:0] grid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_step_q <= '0;
			col_step_q <= '0;
			grid_q     <= cfpt_pkg::GRID_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cfpt_pkg::REG_ROW_STEP: row_step_q <= cfg_data;
				cfpt_pkg::REG_COL_STEP: col_step_q <= cfg_data;
				cfpt_pkg::REG_GRID:     grid_q <= cfg_data[cfpt_pkg::GRID_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Global pipeline enable: hold everything while the output waits
	logic en;
	logic acc;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && s_tready;

	// Phase generation
	logic [cfpt_pkg::TURN_WIDTH-1:0] turn;
	logic                            fe;

	cfpt_phase #(
		.GRID_MAX    (GRID_MAX),
		.PHASE_WIDTH (PHASE_WIDTH)
	) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.row_step    (row_step_q),
		.col_step    (col_step_q),
		.grid_points (grid_q),
		.turn        (turn),
		.frame_end   (fe)
	);

	cfpt_pkg::tag_t tag_s1, tag_s2, tag_s3;
	logic signed [SW-1:0]            re_s1, im_s1;
	logic [cfpt_pkg::TURN_WIDTH-1:0] ang_s1, ang_s2;
	logic signed [XW-1:0]            x_s2, y_s2, x_s3, y_s3;
	logic signed [ZW-1:0]            z_s3;
	logic signed [PWM-1:0]           px, py;

	// Advance the control tags of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= '{vld: acc, fe: fe};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign px = PWM'(re_s1) * GAIN;
	assign py = PWM'(im_s1) * GAIN;

	// Capture, pre-scale by the inverse CORDIC gain, then rotate by quarter turns
	always_ff @(posedge clk) begin
		if (en) begin
			re_s1  <= s_tdata[SW-1:0];
			im_s1  <= s_tdata[2*SW-1:SW];
			ang_s1 <= turn;
			x_s2   <= XW'((px + GAIN_RND) >>> cfpt_pkg::GAIN_SHIFT);
			y_s2   <= XW'((py + GAIN_RND) >>> cfpt_pkg::GAIN_SHIFT);
			ang_s2 <= ang_s1;
			unique case (ang_s2[31:30])
				2'd1: begin x_s3 <= -y_s2; y_s3 <= x_s2;  end
				2'd2: begin x_s3 <= -x_s2; y_s3 <= -y_s2; end
				2'd3: begin x_s3 <= y_s2;  y_s3 <= -x_s2; end
				default: begin x_s3 <= x_s2; y_s3 <= y_s2; end
			endcase
			z_s3   <= {2'b00, ang_s2[29:0]};
		end
	end

	// Row of rotation cells
	cfpt_pkg::tag_t       tag_c [0:ROTATION_STAGES];
	logic signed [XW-1:0] x_c   [0:ROTATION_STAGES];
	logic signed [XW-1:0] y_c   [0:ROTATION_STAGES];
	logic signed [ZW-1:0] z_c   [0:ROTATION_STAGES];

	assign tag_c[0] = tag_s3;
	assign x_c[0]   = x_s3;
	assign y_c[0]   = y_s3;
	assign z_c[0]   = z_s3;

	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
		cfpt_cell #(
			.XW  (XW),
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tag_in  (tag_c[i]),
			.x_in    (x_c[i]),
			.y_in    (y_c[i]),
			.z_in    (z_c[i]),
			.tag_out (tag_c[i+1]),
			.x_out   (x_c[i+1]),
			.y_out   (y_c[i+1]),
			.z_out   (z_c[i+1])
		);
	end

	// Round away the guard bits and saturate
	logic signed [XW-1:0] xr, yr;
	logic signed [SW-1:0] re_sat, im_sat;

	always_comb begin
		xr = (x_c[ROTATION_STAGES] + OUT_RND) >>> GB;
		yr = (y_c[ROTATION_STAGES] + OUT_RND) >>> GB;
		if (xr > SAT_HI) begin
			re_sat = SAT_HI[SW-1:0];
		end else if (xr < SAT_LO) begin
			re_sat = SAT_LO[SW-1:0];
		end else begin
			re_sat = xr[SW-1:0];
		end
		if (yr > SAT_HI) begin
			im_sat = SAT_HI[SW-1:0];
		end else if (yr < SAT_LO) begin
			im_sat = SAT_LO[SW-1:0];
		end else begin
			im_sat = yr[SW-1:0];
		end
	end

	// Output register
	logic                 out_vld_q;
	logic                 out_last_q;
	logic signed [SW-1:0] out_re_q, out_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= tag_c[ROTATION_STAGES].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_last_q <= tag_c[ROTATION_STAGES].fe;
			out_re_q   <= re_sat;
			out_im_q   <= im_sat;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = DW'({out_im_q, out_re_q});

	a_accept_tagged: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> tag_s1.vld)
		else $error("accepted sample lost its valid tag");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(x_s3) && $stable(z_s3) && $stable(tag_s3))
		else $error("pipeline moved during output stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !tag_c[ROTATION_STAGES].vld |=> !m_tvalid)
		else $error("output valid without a sample behind it");

endmodule

`default_nettype wire

@@ design/cfpt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cfpt_cell #(
	parameter int XW  = 32,
	parameter int IDX = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire cfpt_pkg::tag_t    tag_in,
	input  wire signed [XW-1:0]    x_in,
	input  wire signed [XW-1:0]    y_in,
	input  wire signed [cfpt_pkg::ZW-1:0] z_in,
	output cfpt_pkg::tag_t         tag_out,
	output logic signed [XW-1:0]   x_out,
	output logic signed [XW-1:0]   y_out,
	output logic signed [cfpt_pkg::ZW-1:0] z_out
);

	localparam logic signed [cfpt_pkg::ZW-1:0] ANGLE = cfpt_pkg::ATAN_TURNS[IDX];

	cfpt_pkg::tag_t                tag_q;
	logic signed [XW-1:0]          x_q;
	logic signed [XW-1:0]          y_q;
	logic signed [cfpt_pkg::ZW-1:0] z_q;
	logic signed [XW-1:0]          dx;
	logic signed [XW-1:0]          dy;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	// Advance the control tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	// Rotate by one micro-angle toward zero residual phase
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[cfpt_pkg::ZW-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ANGLE;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ANGLE;
			end
		end
	end

	assign tag_out = tag_q;
	assign x_out   = x_q;
	assign y_out   = y_q;
	assign z_out   = z_q;

endmodule

`default_nettype wire

@@ design/cfpt_phase.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cfpt_phase #(
	parameter int GRID_MAX    = cfpt_pkg::GRID_MAX_DEF,
	parameter int PHASE_WIDTH = cfpt_pkg::PHASE_WIDTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                acc,
	input  wire [cfpt_pkg::STEP_WIDTH-1:0]     row_step,
	input  wire [cfpt_pkg::STEP_WIDTH-1:0]     col_step,
	input  wire [cfpt_pkg::GRID_WIDTH-1:0]     grid_points,
	output logic [cfpt_pkg::TURN_WIDTH-1:0]    turn,
	output logic                               frame_end
);

	localparam int PW = PHASE_WIDTH;
	localparam int SW = cfpt_pkg::STEP_WIDTH;
	localparam int TW = cfpt_pkg::TURN_WIDTH;
	localparam int IW = (GRID_MAX > 2) ? $clog2(GRID_MAX) : 1;
	localparam int GW = cfpt_pkg::GRID_WIDTH;
	localparam int KW = (GW > IW + 1) ? GW : IW + 1;
	localparam int KC = (KW > $clog2(GRID_MAX + 1)) ? KW : $clog2(GRID_MAX + 1);
	localparam int MW = KC + PW;

	logic [IW-1:0] row_idx_q;
	logic [IW-1:0] col_idx_q;
	logic [PW-1:0] row_acc_q;
	logic [PW-1:0] pix_acc_q;

	logic [KC-1:0]    gp_ext;
	logic [KC-1:0]    n;
	logic [KC-1:0]    half;
	logic [PW+SW-1:0] rs_wide;
	logic [PW+SW-1:0] cs_wide;
	logic [PW-1:0]    rs;
	logic [PW-1:0]    cs;
	logic [MW-1:0]    half_rs;
	logic [MW-1:0]    half_cs;
	logic [PW-1:0]    row_base;
	logic [PW-1:0]    pix;
	logic [PW+TW-1:0] turn_wide;
	logic [IW:0]      col_next;
	logic [IW:0]      row_next;
	logic             col_wrap;
	logic             row_wrap;

	// Clamp the grid size into its legal range
	always_comb begin
		gp_ext = KC'(grid_points);
		if (gp_ext < KC'(2)) begin
			n = KC'(2);
		end else if (gp_ext > KC'(GRID_MAX)) begin
			n = KC'(GRID_MAX);
		end else begin
			n = gp_ext;
		end
		half = n >> 1;
	end

	// Scale the 2^-32 turn steps to the accumulator width
	assign rs_wide = {row_step, {PW{1'b0}}};
	assign cs_wide = {col_step, {PW{1'b0}}};
	assign rs      = rs_wide[PW+SW-1:SW];
	assign cs      = cs_wide[PW+SW-1:SW];
	assign half_rs = MW'(half) * MW'(rs);
	assign half_cs = MW'(half) * MW'(cs);

	// Reload the start phase at frame start and row start
	always_comb begin
		if (row_idx_q == '0 && col_idx_q == '0) begin
			row_base = PW'(0) - half_rs[PW-1:0];
		end else begin
			row_base = row_acc_q;
		end
		if (col_idx_q == '0) begin
			pix = row_base - half_cs[PW-1:0];
		end else begin
			pix = pix_acc_q;
		end
	end

	assign turn_wide = {pix, {TW{1'b0}}};
	assign turn      = turn_wide[PW+TW-1:PW];

	// Wrap the counters against the current grid size
	assign col_next  = {1'b0, col_idx_q} + (IW+1)'(1);
	assign row_next  = {1'b0, row_idx_q} + (IW+1)'(1);
	assign col_wrap  = KC'(col_next) >= n;
	assign row_wrap  = KC'(row_next) >= n;
	assign frame_end = col_wrap && row_wrap;

	// Advance position and phase on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_idx_q <= '0;
			col_idx_q <= '0;
			row_acc_q <= '0;
			pix_acc_q <= '0;
		end else if (acc) begin
			pix_acc_q <= pix + cs;
			if (col_wrap) begin
				col_idx_q <= '0;
				row_acc_q <= row_base + rs;
				row_idx_q <= row_wrap ? '0 : row_next[IW-1:0];
			end else begin
				col_idx_q <= col_next[IW-1:0];
				row_acc_q <= row_base;
			end
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && frame_end |=> row_idx_q == '0 && col_idx_q == '0)
		else $error("position not cleared after frame end");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> col_idx_q == '0 || col_idx_q == $past(col_idx_q) + IW'(1))
		else $error("column counter skipped");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(col_idx_q) && $stable(row_idx_q) && $stable(pix_acc_q))
		else $error("phase state moved without a transaction");

endmodule

`default_nettype wire
